// ----- rtl/core/whlru_pkg.sv -----
// shared types, constants and codes of the windowed lru hash table
package whlru_pkg;

   // table geometry
   localparam int TABLE_DEPTH = 1024;
   localparam int WINDOW      = 4;
   localparam int MIN_ENTRIES = 4;
   localparam int IDX_W       = $clog2(TABLE_DEPTH);
   localparam int NUM_W       = IDX_W + 1;
   localparam int RCNT_W      = $clog2(WINDOW + 1);

   // field widths
   localparam int CFG_W  = 11;
   localparam int KEY_W  = 32;
   localparam int DATA_W = 32;
   localparam int TIME_W = 32;
   localparam int SLOT_W = 10;

   // key reduction: remainder bits retired per cycle
   localparam int MOD_BITS  = 4;
   localparam int MOD_STEPS = KEY_W / MOD_BITS;
   localparam int MSTEP_W   = $clog2(MOD_STEPS);

   // register file
   localparam int                CSR_ADDR_W      = 3;
   localparam logic              CSR_IDX_ENTRIES = 1'b0;
   localparam logic [CFG_W-1:0]  ENTRIES_RESET   = CFG_W'(TABLE_DEPTH);

   // operation codes
   localparam logic OP_INSERT = 1'b0;
   localparam logic OP_LOOKUP = 1'b1;

   // controller states
   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_MOD,
      ST_READ,
      ST_DRAIN,
      ST_WRITE,
      ST_RESP
   } state_type;

   // controller to datapath
   typedef struct packed {
      logic clr_en;
      logic load;
      logic mod_step;
      logic rd_en;
      logic commit;
      logic res_load;
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic clr_last;
      logic mod_last;
      logic rd_last;
      logic rsp_free;
   } sts_type;

endpackage

// ----- rtl/core/windowed_lru_hash_table.sv -----
// top level of the windowed lru hash table: register port, controller, datapath
// a request is taken only in the idle state and is worked in turn by the key remainder
//   unit, the four single-port bucket reads that follow it and the entry write; the next
//   request is taken only once the response of the last one has been loaded
// reset: synchronous; afterwards a clearing pass empties the time
//   store, during which requests are stalled (register writes are taken)
module windowed_lru_hash_table (
   input  logic                                  clock,
   input  logic                                  reset,
   // request channel
   input  logic                                  req_valid,
   output logic                                  req_stall,
   input  logic                                  req_operation,
   input  logic [whlru_pkg::KEY_W-1:0]           req_key,
   input  logic signed [whlru_pkg::DATA_W-1:0]   req_value,
   input  logic [whlru_pkg::TIME_W-1:0]          req_now,
   // response channel
   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output logic                                  rsp_hit,
   output logic signed [whlru_pkg::DATA_W-1:0]   rsp_found_value,
   output logic [whlru_pkg::TIME_W-1:0]          rsp_replaced_time,
   output logic [whlru_pkg::SLOT_W-1:0]          rsp_slot,
   // register port
   input  logic                                  csr_psel,
   input  logic                                  csr_penable,
   input  logic                                  csr_pwrite,
   input  logic [whlru_pkg::CSR_ADDR_W-1:0]      csr_paddr,
   input  logic [31:0]                           csr_pwdata,
   output logic [31:0]                           csr_prdata,
   output logic                                  csr_pready
);
   import whlru_pkg::*;

   logic [CFG_W-1:0] entries_ff;
   logic             csr_wr;
   cmd_type          cmd;
   sts_type          sts;

   // register write and read
   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         entries_ff <= ENTRIES_RESET;
      end else if (csr_wr && (csr_paddr[2] == CSR_IDX_ENTRIES)) begin
         entries_ff <= csr_pwdata[CFG_W-1:0];
      end
   end

   always_comb begin
      if (csr_paddr[2] == CSR_IDX_ENTRIES) begin
         csr_prdata = {{(32 - CFG_W){1'b0}}, entries_ff};
      end else begin
         csr_prdata = '0;
      end
   end

   // controller
   whlru_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .sts       (sts),
      .cmd       (cmd),
      .req_stall (req_stall)
   );

   // datapath
   whlru_dp u_dp (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .sts               (sts),
      .cfg_entries       (entries_ff),
      .req_operation     (req_operation),
      .req_key           (req_key),
      .req_value         (req_value),
      .req_now           (req_now),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_hit           (rsp_hit),
      .rsp_found_value   (rsp_found_value),
      .rsp_replaced_time (rsp_replaced_time),
      .rsp_slot          (rsp_slot)
   );

   // a response is never loaded over one that is still undelivered
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      cmd.res_load |-> (!rsp_valid || !rsp_stall))
      else $error("response register overwritten");

   // once a request is taken the block stays busy in the next cycle
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> req_stall)
      else $error("request taken while previous one in progress");

   // no request is taken during the clearing pass
   a_stall_while_clearing: assert property (@(posedge clock) disable iff (reset)
      cmd.clr_en |-> req_stall)
      else $error("request window open during clearing pass");

   // the stores are not read and written for an item in the same cycle
   a_read_write_apart: assert property (@(posedge clock) disable iff (reset)
      !(cmd.rd_en && (cmd.commit || cmd.clr_en)))
      else $error("bucket read overlaps a write");

endmodule

// ----- rtl/core/whlru_ctrl.sv -----
// controller state machine of the windowed lru hash table
module whlru_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   input  whlru_pkg::sts_type sts,
   output whlru_pkg::cmd_type cmd,
   output logic              req_stall
);
   import whlru_pkg::*;

   state_type state_ff;
   state_type state_in;

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   // next state and commands
   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_stall = 1'b1;
      unique case (state_ff)
         ST_CLEAR: begin
            cmd.clr_en = 1'b1;
            if (sts.clr_last) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = ST_MOD;
            end
         end
         ST_MOD: begin
            cmd.mod_step = 1'b1;
            if (sts.mod_last) begin
               state_in = ST_READ;
            end
         end
         ST_READ: begin
            cmd.rd_en = 1'b1;
            if (sts.rd_last) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            state_in = ST_WRITE;
         end
         ST_WRITE: begin
            cmd.commit = 1'b1;
            state_in   = ST_RESP;
         end
         ST_RESP: begin
            if (sts.rsp_free) begin
               cmd.res_load = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

// ----- rtl/core/whlru_dp.sv -----
// datapath of the windowed lru hash table: key reduction, bucket stores, selection
module whlru_dp (
   input  logic                                  clock,
   input  logic                                  reset,
   input  whlru_pkg::cmd_type                    cmd,
   output whlru_pkg::sts_type                    sts,
   input  logic [whlru_pkg::CFG_W-1:0]           cfg_entries,
   input  logic                                  req_operation,
   input  logic [whlru_pkg::KEY_W-1:0]           req_key,
   input  logic signed [whlru_pkg::DATA_W-1:0]   req_value,
   input  logic [whlru_pkg::TIME_W-1:0]          req_now,
   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output logic                                  rsp_hit,
   output logic signed [whlru_pkg::DATA_W-1:0]   rsp_found_value,
   output logic [whlru_pkg::TIME_W-1:0]          rsp_replaced_time,
   output logic [whlru_pkg::SLOT_W-1:0]          rsp_slot
);
   import whlru_pkg::*;

   // bucket stores
   logic [KEY_W-1:0]  key_mem  [TABLE_DEPTH];
   logic [TIME_W-1:0] time_mem [TABLE_DEPTH];
   logic [DATA_W-1:0] val_mem  [TABLE_DEPTH];

   // request capture
   logic              op_ff;
   logic [KEY_W-1:0]  key_ff;
   logic [DATA_W-1:0] val_ff;
   logic [TIME_W-1:0] now_ff;

   // reduction and bucket walk
   logic [KEY_W-1:0]   div_ff;
   logic [KEY_W-1:0]   div_in;
   logic [MSTEP_W-1:0] mstep_ff;
   logic [IDX_W-1:0]   bkt_ff;
   logic [IDX_W-1:0]   bkt_in;
   logic [IDX_W-1:0]   rem_next;
   logic [KEY_W-1:0]   hash_ff;
   logic [RCNT_W-1:0]  rcnt_ff;
   logic [NUM_W-1:0]   n_eff;
   logic [NUM_W-1:0]   bkt_inc;

   // read pipeline
   logic              rdv_ff;
   logic              rfirst_ff;
   logic [IDX_W-1:0]  raddr_ff;
   logic [KEY_W-1:0]  rkey_ff;
   logic [TIME_W-1:0] rtime_ff;
   logic [DATA_W-1:0] rval_ff;

   // selection
   logic              found_ff;
   logic [TIME_W-1:0] best_time_ff;
   logic [IDX_W-1:0]  best_slot_ff;
   logic [DATA_W-1:0] fval_ff;

   // clearing pass
   logic [IDX_W-1:0] clr_cnt_ff;

   // time store write port
   logic              twr_en;
   logic [IDX_W-1:0]  twr_addr;
   logic [TIME_W-1:0] twr_data;
   logic              write_entry;

   // response register
   logic rsp_valid_ff;
   logic rsp_valid_in;

   // effective bucket count, saturated to the legal range
   always_comb begin
      if (int'(cfg_entries) < MIN_ENTRIES) begin
         n_eff = NUM_W'(MIN_ENTRIES);
      end else if (int'(cfg_entries) > TABLE_DEPTH) begin
         n_eff = NUM_W'(TABLE_DEPTH);
      end else begin
         n_eff = NUM_W'(cfg_entries);
      end
   end

   // restoring remainder, several dividend bits per cycle
   always_comb begin
      logic [NUM_W-1:0] t;
      logic [IDX_W-1:0] r;
      r = bkt_ff;
      for (int j = 0; j < MOD_BITS; j++) begin
         t = {r, div_ff[KEY_W-1-j]};
         if (t >= n_eff) begin
            t = t - n_eff;
         end
         r = t[IDX_W-1:0];
      end
      rem_next = r;
      div_in   = div_ff << MOD_BITS;
   end

   // next bucket of the window: hash wrap goes to bucket zero
   assign bkt_inc = {1'b0, bkt_ff} + NUM_W'(1);
   always_comb begin
      if (&hash_ff) begin
         bkt_in = '0;
      end else if (bkt_inc == n_eff) begin
         bkt_in = '0;
      end else begin
         bkt_in = bkt_inc[IDX_W-1:0];
      end
   end

   assign sts.mod_last = (mstep_ff == MSTEP_W'(MOD_STEPS - 1));
   assign sts.rd_last  = (rcnt_ff == RCNT_W'(WINDOW - 1));
   assign sts.clr_last = (clr_cnt_ff == IDX_W'(TABLE_DEPTH - 1));
   assign sts.rsp_free = !rsp_valid_ff || !rsp_stall;

   // request capture, reduction and walk registers
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         op_ff    <= req_operation;
         key_ff   <= req_key;
         val_ff   <= req_value;
         now_ff   <= req_now;
         div_ff   <= req_key;
         hash_ff  <= req_key;
         bkt_ff   <= '0;
         mstep_ff <= '0;
         rcnt_ff  <= '0;
      end else if (cmd.mod_step) begin
         div_ff   <= div_in;
         bkt_ff   <= rem_next;
         mstep_ff <= mstep_ff + MSTEP_W'(1);
      end else if (cmd.rd_en) begin
         bkt_ff  <= bkt_in;
         hash_ff <= hash_ff + KEY_W'(1);
         rcnt_ff <= rcnt_ff + RCNT_W'(1);
      end
   end

   // read tag pipeline
   always_ff @(posedge clock) begin
      if (reset) begin
         rdv_ff <= 1'b0;
      end else begin
         rdv_ff <= cmd.rd_en;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.rd_en) begin
         rfirst_ff <= (rcnt_ff == '0);
         raddr_ff  <= bkt_ff;
      end
   end

   // clearing pass counter
   always_ff @(posedge clock) begin
      if (reset) begin
         clr_cnt_ff <= '0;
      end else if (cmd.clr_en) begin
         clr_cnt_ff <= clr_cnt_ff + IDX_W'(1);
      end
   end

   // time store write port: clearing pass or commit
   assign write_entry = cmd.commit && (op_ff == OP_INSERT);
   always_comb begin
      if (cmd.clr_en) begin
         twr_en   = 1'b1;
         twr_addr = clr_cnt_ff;
         twr_data = '0;
      end else begin
         twr_en   = write_entry || (cmd.commit && found_ff);
         twr_addr = best_slot_ff;
         twr_data = now_ff;
      end
   end

   // bucket stores
   always_ff @(posedge clock) begin
      if (twr_en) begin
         time_mem[twr_addr] <= twr_data;
      end
      if (cmd.rd_en) begin
         rtime_ff <= time_mem[bkt_ff];
      end
   end

   always_ff @(posedge clock) begin
      if (write_entry) begin
         key_mem[best_slot_ff] <= key_ff;
      end
      if (cmd.rd_en) begin
         rkey_ff <= key_mem[bkt_ff];
      end
   end

   always_ff @(posedge clock) begin
      if (write_entry) begin
         val_mem[best_slot_ff] <= val_ff;
      end
      if (cmd.rd_en) begin
         rval_ff <= val_mem[bkt_ff];
      end
   end

   // hit flag
   always_ff @(posedge clock) begin
      if (reset) begin
         found_ff <= 1'b0;
      end else if (cmd.load) begin
         found_ff <= 1'b0;
      end else if (rdv_ff && (op_ff == OP_LOOKUP) && !found_ff
                   && (rtime_ff != '0) && (rkey_ff == key_ff)) begin
         found_ff <= 1'b1;
      end
   end

   // oldest bucket on insert, first matching bucket on lookup
   always_ff @(posedge clock) begin
      if (rdv_ff) begin
         if (op_ff == OP_INSERT) begin
            if (rfirst_ff || (rtime_ff < best_time_ff)) begin
               best_time_ff <= rtime_ff;
               best_slot_ff <= raddr_ff;
            end
         end else if (!found_ff && (rtime_ff != '0) && (rkey_ff == key_ff)) begin
            best_slot_ff <= raddr_ff;
            fval_ff      <= rval_ff;
         end
      end
   end

   // response valid
   always_comb begin
      if (cmd.res_load) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // response payload
   always_ff @(posedge clock) begin
      if (cmd.res_load) begin
         if (op_ff == OP_INSERT) begin
            rsp_hit           <= 1'b0;
            rsp_found_value   <= '0;
            rsp_replaced_time <= best_time_ff;
            rsp_slot          <= SLOT_W'(best_slot_ff);
         end else begin
            rsp_hit           <= found_ff;
            rsp_found_value   <= found_ff ? fval_ff : '0;
            rsp_replaced_time <= '0;
            rsp_slot          <= found_ff ? SLOT_W'(best_slot_ff) : '0;
         end
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

// ----- tb/windowed_lru_hash_table_tb.sv -----
// self-checking testbench of the windowed lru hash table, with its own shadow table model
module windowed_lru_hash_table_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import whlru_pkg::*;

   localparam logic [CSR_ADDR_W-1:0] ENTRIES_ADDR = CSR_ADDR_W'(4 * int'(CSR_IDX_ENTRIES));
   localparam int SETTLE_CYCLES = 24;
   localparam int LONG_HOLD     = 320;
   localparam int RANDOM_PHASES = 10;
   localparam int PER_PHASE     = 113;

   typedef struct {
      logic                     op;
      logic [KEY_W-1:0]         key;
      logic signed [DATA_W-1:0] value;
      logic [TIME_W-1:0]        now;
   } request_type;

   typedef struct {
      logic                     hit;
      logic signed [DATA_W-1:0] found_value;
      logic [TIME_W-1:0]        replaced_time;
      logic [SLOT_W-1:0]        slot;
   } reply_type;

   // clock and reset
   logic clock = 1'b0;
   logic reset = 1'b1;

   // request channel
   logic                     req_valid     = 1'b0;
   logic                     req_stall;
   logic                     req_operation = OP_INSERT;
   logic [KEY_W-1:0]         req_key       = '0;
   logic signed [DATA_W-1:0] req_value     = '0;
   logic [TIME_W-1:0]        req_now       = '0;

   // response channel
   logic                     rsp_valid;
   logic                     rsp_stall     = 1'b0;
   logic                     rsp_hit;
   logic signed [DATA_W-1:0] rsp_found_value;
   logic [TIME_W-1:0]        rsp_replaced_time;
   logic [SLOT_W-1:0]        rsp_slot;

   // register port
   logic                  csr_psel    = 1'b0;
   logic                  csr_penable = 1'b0;
   logic                  csr_pwrite  = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_paddr   = '0;
   logic [31:0]           csr_pwdata  = '0;
   logic [31:0]           csr_prdata;
   logic                  csr_pready;

   // shadow copy of the table and its size register
   logic [KEY_W-1:0]  shadow_key   [TABLE_DEPTH];
   logic [TIME_W-1:0] shadow_stamp [TABLE_DEPTH];
   logic [DATA_W-1:0] shadow_val   [TABLE_DEPTH];
   logic [CFG_W-1:0]  shadow_entries = ENTRIES_RESET;

   request_type      pending_requests [$];
   reply_type        awaited_replies  [$];
   logic [KEY_W-1:0] key_pool         [$];

   int errors          = 0;
   int insert_count    = 0;
   int lookup_count    = 0;
   int hit_count       = 0;
   int eviction_count  = 0;
   int size_count      = 0;
   int send_gap        = 0;
   int stall_left      = 0;
   int hold_left       = 0;
   int hold_ticket     = 0;
   int hold_served     = 0;
   logic [TIME_W-1:0] tick = 32'd20;
   bit   sender_idling   = 1'b1;
   bit   receiver_idling = 1'b1;
   logic req_accepted    = 1'b0;

   windowed_lru_hash_table dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_operation     (req_operation),
      .req_key           (req_key),
      .req_value         (req_value),
      .req_now           (req_now),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_hit           (rsp_hit),
      .rsp_found_value   (rsp_found_value),
      .rsp_replaced_time (rsp_replaced_time),
      .rsp_slot          (rsp_slot),
      .csr_psel          (csr_psel),
      .csr_penable       (csr_penable),
      .csr_pwrite        (csr_pwrite),
      .csr_paddr         (csr_paddr),
      .csr_pwdata        (csr_pwdata),
      .csr_prdata        (csr_prdata),
      .csr_pready        (csr_pready)
   );

   always #5 clock = ~clock;

   // bucket of window position i, with the key sum wrapping at 32 bits
   function automatic int unsigned home_of(logic [KEY_W-1:0] key, int unsigned i,
                                           int unsigned n);
      logic [KEY_W-1:0] h;
      h = key + i;
      return h % n;
   endfunction

   // shadow table access: victim choice on insert, first match on lookup
   function automatic reply_type table_access(request_type rq);
      reply_type   rp;
      int unsigned n;
      int unsigned b;
      int unsigned victim;
      int unsigned i;
      rp.hit = 1'b0;
      rp.found_value = '0;
      rp.replaced_time = '0;
      rp.slot = '0;
      n = shadow_entries;
      if (n < MIN_ENTRIES) n = MIN_ENTRIES;
      if (n > TABLE_DEPTH) n = TABLE_DEPTH;
      if (rq.op == OP_INSERT) begin
         victim = home_of(rq.key, 0, n);
         for (i = 1; i < WINDOW; i++) begin
            b = home_of(rq.key, i, n);
            if (shadow_stamp[b] < shadow_stamp[victim]) victim = b;
         end
         rp.replaced_time = shadow_stamp[victim];
         shadow_stamp[victim] = rq.now;
         shadow_key[victim] = rq.key;
         shadow_val[victim] = rq.value;
         rp.slot = SLOT_W'(victim);
      end else begin
         for (i = 0; i < WINDOW; i++) begin
            b = home_of(rq.key, i, n);
            if (shadow_stamp[b] != 0 && shadow_key[b] == rq.key) begin
               shadow_stamp[b] = rq.now;
               rp.hit = 1'b1;
               rp.found_value = shadow_val[b];
               rp.slot = SLOT_W'(b);
               break;
            end
         end
      end
      return rp;
   endfunction

   function automatic void queue_request(logic op, logic [KEY_W-1:0] key,
                                         logic [DATA_W-1:0] value, logic [TIME_W-1:0] now);
      request_type rq;
      rq.op = op;
      rq.key = key;
      rq.value = value;
      rq.now = now;
      pending_requests.push_back(rq);
   endfunction

   // mostly recently inserted keys, so lookups hit and windows fill and evict
   function automatic request_type random_request();
      request_type rq;
      int unsigned pick;
      pick = $urandom_range(0, 99);
      rq.op = ($urandom_range(0, 99) < 45) ? OP_INSERT : OP_LOOKUP;
      rq.value = $urandom;
      if (key_pool.size() != 0 && pick < 65)
         rq.key = key_pool[$urandom_range(0, key_pool.size() - 1)];
      else if (pick < 85)
         rq.key = $urandom_range(0, 255);
      else if (pick < 92)
         rq.key = 32'hFFFF_FFFF - $urandom_range(0, 9);
      else
         rq.key = $urandom;
      tick = tick + $urandom_range(0, 2);
      if ($urandom_range(0, 99) < 6) begin
         rq.now = $urandom;
         if (rq.now == 0) rq.now = 1;
      end else begin
         rq.now = tick;
      end
      if (rq.op == OP_INSERT) begin
         key_pool.push_back(rq.key);
         if (key_pool.size() > 24) void'(key_pool.pop_front());
      end
      return rq;
   endfunction

   // register write of the bucket count, then read back
   task automatic set_entries(logic [CFG_W-1:0] count);
      logic [31:0] got;
      @(negedge clock);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= ENTRIES_ADDR;
      csr_pwdata <= {(32 - CFG_W)'($urandom_range(0, (1 << (32 - CFG_W)) - 1)), count};
      @(negedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      shadow_entries = count;
      size_count++;
      @(negedge clock);
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      @(negedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      got = csr_prdata;
      if (got[CFG_W-1:0] !== count) begin
         $error("entries_in_use readback: expected %0d, got %0d", count, got[CFG_W-1:0]);
         errors++;
      end
      @(negedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
   endtask

   // sender pauses until every outstanding response is back
   task automatic drain_all();
      while (pending_requests.size() != 0 || req_valid || awaited_replies.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // request driver
   always @(negedge clock) begin
      request_type nxt;
      if (!reset && (!req_valid || req_accepted)) begin
         if (send_gap != 0) begin
            send_gap <= send_gap - 1;
            req_valid <= 1'b0;
         end else if (pending_requests.size() != 0 && sender_idling
                      && $urandom_range(0, 5) == 0) begin
            send_gap <= $urandom_range(0, 13);
            req_valid <= 1'b0;
         end else if (pending_requests.size() != 0) begin
            nxt = pending_requests.pop_front();
            req_valid <= 1'b1;
            req_operation <= nxt.op;
            req_key <= nxt.key;
            req_value <= nxt.value;
            req_now <= nxt.now;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // response stall: long hold on request, else random bursts
   always @(negedge clock) begin
      if (hold_served != hold_ticket) begin
         hold_served <= hold_ticket;
         hold_left <= LONG_HOLD;
         rsp_stall <= 1'b1;
      end else if (hold_left != 0) begin
         hold_left <= hold_left - 1;
         rsp_stall <= 1'b1;
      end else if (stall_left != 0) begin
         stall_left <= stall_left - 1;
         rsp_stall <= 1'b1;
      end else if (receiver_idling && $urandom_range(0, 4) == 0) begin
         stall_left <= $urandom_range(0, 13);
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   // monitor: check responses, predict accepted requests
   always @(posedge clock) begin
      reply_type   want;
      request_type seen;
      req_accepted <= !reset && req_valid && !req_stall;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (awaited_replies.size() == 0) begin
            $error("response with no request outstanding");
            errors++;
         end else begin
            want = awaited_replies.pop_front();
            if (rsp_hit !== want.hit) begin
               $error("hit: expected %0d, got %0d", want.hit, rsp_hit);
               errors++;
            end
            if (rsp_found_value !== want.found_value) begin
               $error("found_value: expected %0d, got %0d", want.found_value, rsp_found_value);
               errors++;
            end
            if (rsp_replaced_time !== want.replaced_time) begin
               $error("replaced_time: expected %0d, got %0d",
                      want.replaced_time, rsp_replaced_time);
               errors++;
            end
            if (rsp_slot !== want.slot) begin
               $error("slot: expected %0d, got %0d", want.slot, rsp_slot);
               errors++;
            end
         end
      end
      if (!reset && req_valid && !req_stall) begin
         seen.op = req_operation;
         seen.key = req_key;
         seen.value = req_value;
         seen.now = req_now;
         want = table_access(seen);
         awaited_replies.push_back(want);
         if (seen.op == OP_INSERT) begin
            insert_count++;
            if (want.replaced_time != 0) eviction_count++;
         end else begin
            lookup_count++;
            if (want.hit) hit_count++;
         end
      end
   end

   // watchdog
   initial begin
      #3_000_000;
      $display("DONE: errors detected");
      $finish;
   end

   // stimulus sequence
   initial begin
      logic [CFG_W-1:0] sizes [RANDOM_PHASES];
      int p;
      int k;
      sizes = '{11'd0, 11'd4, 11'd7, 11'd1024, 11'd16, 11'd2047, 11'd100, 11'd5,
                11'd1000, 11'd64};
      foreach (shadow_stamp[j]) begin
         shadow_stamp[j] = '0;
         shadow_key[j] = '0;
         shadow_val[j] = '0;
      end
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // reset size: empty miss, field extremes, zero stamp, equal-time ties
      queue_request(OP_LOOKUP, 32'h0000_0000, 32'h0, 32'd1);
      queue_request(OP_INSERT, 32'h0000_0000, 32'h7FFF_FFFF, 32'd1);
      queue_request(OP_INSERT, 32'hFFFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF);
      queue_request(OP_LOOKUP, 32'h0000_0000, 32'h5555_5555, 32'd2);
      queue_request(OP_LOOKUP, 32'hFFFF_FFFF, 32'hAAAA_AAAA, 32'd3);
      queue_request(OP_INSERT, 32'h1234_5678, 32'hFFFF_FFFF, 32'd0);
      queue_request(OP_LOOKUP, 32'h1234_5678, 32'h0, 32'd4);
      for (k = 0; k < 5; k++) queue_request(OP_INSERT, 32'd100, 32'(k + 1), 32'd5);
      queue_request(OP_LOOKUP, 32'd100, 32'h0, 32'd6);
      queue_request(OP_LOOKUP, 32'd101, 32'h0, 32'd7);
      drain_all();

      // odd size with key wrap: the same bucket twice in one window
      set_entries(11'd5);
      for (k = 0; k < 3; k++) queue_request(OP_INSERT, 32'hFFFF_FFFF, 32'(k + 1), 32'd8);
      queue_request(OP_LOOKUP, 32'hFFFF_FFFF, 32'h0, 32'd9);
      drain_all();

      // below the minimum size
      set_entries(11'd3);
      queue_request(OP_INSERT, 32'd3, 32'd5, 32'd10);
      queue_request(OP_LOOKUP, 32'd3, 32'h0, 32'd11);
      queue_request(OP_LOOKUP, 32'd7, 32'h0, 32'd12);
      drain_all();

      // above the table depth
      set_entries(11'd2047);
      queue_request(OP_INSERT, 32'd1023, -32'sd5, 32'd13);
      queue_request(OP_LOOKUP, 32'd1023, 32'h0, 32'd14);
      drain_all();

      // random phases over a spread of table sizes
      for (p = 0; p < RANDOM_PHASES; p++) begin
         set_entries(sizes[p]);
         sender_idling = (p != 3) && (p != RANDOM_PHASES - 1);
         receiver_idling = (p != RANDOM_PHASES - 1);
         if (p == 3) hold_ticket = hold_ticket + 1;
         for (k = 0; k < PER_PHASE; k++) pending_requests.push_back(random_request());
         drain_all();
      end

      $display("covered %0d inserts (%0d evictions) and %0d lookups (%0d hits)",
               insert_count, eviction_count, lookup_count, hit_count);
      $display("across %0d register settings, with stalls on both channels", size_count);
      if (errors == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule
